FILE: design/sslb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sslb_pkg - shared types and constants of the SPI to serial line bridge
// Event kinds, SPI command and mode codes, frame steps, receiver and transmitter step codes.
// ----------------------------------------------------------------------------
package sslb_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int OVERSAMPLE_DEF = 16;
    localparam int LED_PHASES     = 6;

    typedef enum logic [1:0] {
        EV_SPI  = 2'd0,
        EV_LINE = 2'd1,
        EV_LED  = 2'd2,
        EV_NONE = 2'd3
    } event_t;

    localparam logic [7:0] SYNC_OCTET = 8'hFF;
    localparam logic [7:0] REPLY_ACK  = 8'hAA;
    localparam logic [7:0] REPLY_PAD  = 8'h55;
    localparam logic [7:0] REPLY_NONE = 8'hFF;
    localparam logic [7:0] FREE_FLAG  = 8'h80;

    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_MODE  = 8'h04;
    localparam logic [7:0] CMD_LED   = 8'h05;
    localparam logic [7:0] CMD_FREE  = 8'h06;

    localparam logic [7:0] MODE_SILENT  = 8'h01;
    localparam logic [7:0] MODE_TONE_LO = 8'h02;
    localparam logic [7:0] MODE_TONE_HI = 8'h03;
    localparam logic [7:0] MODE_DATA    = 8'h04;

    localparam logic [1:0] RATE_1760 = 2'd0;
    localparam logic [1:0] RATE_3400 = 2'd1;
    localparam logic [1:0] RATE_1200 = 2'd2;

    localparam logic [2:0] FS_CMD  = 3'd0;
    localparam logic [2:0] FS_PAR  = 3'd1;
    localparam logic [2:0] FS_PAD0 = 3'd2;
    localparam logic [2:0] FS_PAD1 = 3'd3;
    localparam logic [2:0] FS_SYNC = 3'd4;

    localparam logic [3:0] RX_START = 4'd0;
    localparam logic [3:0] RX_STOP  = 4'd9;
    localparam logic [3:0] RX_IDLE  = 4'd15;

    localparam logic [3:0] TX_IDLE     = 4'd0;
    localparam logic [3:0] TX_BIT0     = 4'd1;
    localparam logic [3:0] TX_BIT7     = 4'd8;
    localparam logic [3:0] TX_STOP0    = 4'd9;
    localparam logic [3:0] TX_STOP2    = 4'd11;
    localparam logic [3:0] TX_TONE_HI  = 4'd12;
    localparam logic [3:0] TX_TONE_LO  = 4'd13;
    localparam logic [3:0] TX_SILENT   = 4'd14;

endpackage
`default_nettype wire

FILE: design/spi_to_serial_line_bridge_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spi_to_serial_line_bridge_top - SPI slave to serial line terminal bridge
// Frames SPI octets into commands, runs an oversampled line receiver and a
// line transmitter through two FIFO memories, and scans an LED pattern.
//
// channel  beat                        tdata (low bit up)                  tuser
// s_       one event                   spi_byte, line_in, dial_request     event kind
// m_       one result per event        spi_reply, line_out, tick_rate,     -
//                                      led_bits
//
// One event enters per cycle; its registered result leaves in the cycle
// after acceptance. A FIFO pop reads the memory at the accepting edge and
// the data lands in the reply or transmit shift register on the next cycle,
// bypassed to any event in between. aresetn clears all control state; FIFO
// contents stay unset. s_tready drops only while a result waits on m_tready.
// ----------------------------------------------------------------------------
module spi_to_serial_line_bridge_top #(
    parameter int FIFO_DEPTH = sslb_pkg::FIFO_DEPTH_DEF,
    parameter int OVERSAMPLE = sslb_pkg::OVERSAMPLE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // spi_byte[7:0], line_in[8], dial_request[9]
    input  wire logic [1:0]  s_tuser,   // event kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // spi_reply[7:0], line_out[8], tick_rate[10:9],
                                        // led_bits[13:11]
);

    localparam int PW  = $clog2(FIFO_DEPTH);
    localparam int PHW = $clog2(OVERSAMPLE);
    localparam int NL  = sslb_pkg::LED_PHASES;
    localparam int SW  = $clog2(NL);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW:0] used_f(input logic [PW-1:0] w, input logic [PW-1:0] r);
        if (w >= r) begin
            used_f = {1'b0, w} - {1'b0, r};
        end else begin
            used_f = {1'b0, w} + (PW+1)'(FIFO_DEPTH) - {1'b0, r};
        end
    endfunction

    logic                    in_acc;
    sslb_pkg::event_t        ev;
    logic [7:0]              in_byte;
    logic                    in_line;
    logic                    in_dial;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [15:0]             m_tdata_reg, m_tdata_next;

    logic [2:0]              fs_reg, fs_next;
    logic [7:0]              cmd_reg, cmd_next;
    logic [7:0]              rep0_reg, rep0_next;
    logic [7:0]              rep1_reg, rep1_next;
    logic [7:0]              rep2_reg, rep2_next;
    logic [7:0]              last_reg, last_next;
    logic [PW-1:0]           hw_reg, hw_next, hr_reg, hr_next;
    logic [PW-1:0]           lw_reg, lw_next, lr_reg, lr_next;
    logic [3:0]              rx_idx_reg, rx_idx_next;
    logic [PHW-1:0]          rx_ph_reg, rx_ph_next;
    logic [7:0]              rx_sh_reg, rx_sh_next;
    logic [3:0]              tx_step_reg, tx_step_next;
    logic [7:0]              tx_sh_reg, tx_sh_next;
    logic [1:0]              rate_reg, rate_next;
    logic [2:0]              led_pat_reg [NL];
    logic [2:0]              led_pat_next [NL];
    logic [SW-1:0]           scan_reg, scan_next;
    logic                    line_reg, line_next;
    logic [2:0]              drive_reg, drive_next;
    logic                    pend_rd_reg, pend_rd_next;
    logic                    pend_tx_reg, pend_tx_next;

    logic                    h_wr, h_rd, l_wr, l_rd;
    logic [7:0]              h_q, l_q;
    logic [7:0]              rep2_eff, tx_sh_eff;

    assign ev      = sslb_pkg::event_t'(s_tuser);
    assign in_byte = s_tdata[7:0];
    assign in_line = s_tdata[8];
    assign in_dial = s_tdata[9];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rep2_eff  = pend_rd_reg ? l_q : rep2_reg;
    assign tx_sh_eff = pend_tx_reg ? h_q : tx_sh_reg;

    sslb_ram #(.DEPTH(FIFO_DEPTH), .AW(PW)) u_h2l (
        .aclk    (aclk),
        .wr_en   (h_wr),
        .wr_addr (hw_reg),
        .wr_data (in_byte),
        .rd_en   (h_rd),
        .rd_addr (hr_reg),
        .rd_data (h_q)
    );

    sslb_ram #(.DEPTH(FIFO_DEPTH), .AW(PW)) u_l2h (
        .aclk    (aclk),
        .wr_en   (l_wr),
        .wr_addr (lw_reg),
        .wr_data (rx_sh_reg),
        .rd_en   (l_rd),
        .rd_addr (lr_reg),
        .rd_data (l_q)
    );

    always_comb begin
        logic [PW:0]  used_t;
        logic [PHW:0] ph_t;
        logic [3:0]   idx_t;
        logic [1:0]   led_sel;
        logic [5:0]   pat;
        logic [SW:0]  scan_t;

        fs_next      = fs_reg;
        cmd_next     = cmd_reg;
        rep0_next    = rep0_reg;
        rep1_next    = rep1_reg;
        rep2_next    = rep2_eff;
        last_next    = last_reg;
        hw_next      = hw_reg;
        hr_next      = hr_reg;
        lw_next      = lw_reg;
        lr_next      = lr_reg;
        rx_idx_next  = rx_idx_reg;
        rx_ph_next   = rx_ph_reg;
        rx_sh_next   = rx_sh_reg;
        tx_step_next = tx_step_reg;
        tx_sh_next   = tx_sh_eff;
        rate_next    = rate_reg;
        for (int n = 0; n < NL; n++) begin
            led_pat_next[n] = led_pat_reg[n];
        end
        scan_next    = scan_reg;
        line_next    = line_reg;
        drive_next   = drive_reg;
        pend_rd_next = 1'b0;
        pend_tx_next = 1'b0;
        h_wr = 1'b0;
        h_rd = 1'b0;
        l_wr = 1'b0;
        l_rd = 1'b0;
        used_t  = '0;
        ph_t    = '0;
        idx_t   = rx_idx_reg;
        led_sel = in_byte[1:0];
        pat     = in_byte[7:2];
        scan_t  = '0;

        if (in_acc) begin
            case (ev)
                sslb_pkg::EV_SPI: begin
                    if (fs_reg >= sslb_pkg::FS_SYNC) begin
                        if (in_byte == sslb_pkg::SYNC_OCTET) begin
                            last_next = sslb_pkg::REPLY_ACK;
                            fs_next   = sslb_pkg::FS_CMD;
                            rep0_next = {(lw_reg != lr_reg),
                                         (used_f(hw_reg, hr_reg) < (PW+1)'(FIFO_DEPTH / 2)),
                                         (used_f(hw_reg, hr_reg) < (PW+1)'(FIFO_DEPTH - 8)),
                                         in_dial, 4'b0000};
                            rep1_next = sslb_pkg::REPLY_PAD;
                            rep2_next = sslb_pkg::REPLY_ACK;
                        end
                    end else begin
                        case (fs_reg)
                            sslb_pkg::FS_CMD: begin
                                last_next = rep0_reg;
                                cmd_next  = in_byte;
                                if (in_byte == sslb_pkg::CMD_READ) begin
                                    if (lw_reg != lr_reg) begin
                                        l_rd         = 1'b1;
                                        lr_next      = ptr_inc(lr_reg);
                                        used_t       = used_f(lw_reg, lr_next);
                                        rep1_next    = 8'(used_t);
                                        pend_rd_next = 1'b1;
                                    end else begin
                                        rep1_next = sslb_pkg::REPLY_NONE;
                                        rep2_next = sslb_pkg::REPLY_NONE;
                                    end
                                end
                                fs_next = sslb_pkg::FS_PAR;
                            end
                            sslb_pkg::FS_PAR: begin
                                last_next = rep1_reg;
                                case (cmd_reg)
                                    sslb_pkg::CMD_WRITE: begin
                                        if (ptr_inc(hw_reg) != hr_reg) begin
                                            h_wr      = 1'b1;
                                            hw_next   = ptr_inc(hw_reg);
                                            used_t    = (PW+1)'(FIFO_DEPTH)
                                                        - used_f(hw_next, hr_reg);
                                            rep2_next = 8'(used_t);
                                        end else begin
                                            rep2_next = sslb_pkg::REPLY_NONE;
                                        end
                                    end
                                    sslb_pkg::CMD_MODE: begin
                                        case (in_byte)
                                            sslb_pkg::MODE_SILENT: begin
                                                tx_step_next = sslb_pkg::TX_SILENT;
                                                rate_next    = sslb_pkg::RATE_1760;
                                            end
                                            sslb_pkg::MODE_TONE_LO: begin
                                                tx_step_next = sslb_pkg::TX_TONE_HI;
                                                rate_next    = sslb_pkg::RATE_1760;
                                            end
                                            sslb_pkg::MODE_TONE_HI: begin
                                                tx_step_next = sslb_pkg::TX_TONE_HI;
                                                rate_next    = sslb_pkg::RATE_3400;
                                            end
                                            sslb_pkg::MODE_DATA: begin
                                                tx_step_next = sslb_pkg::TX_IDLE;
                                                rate_next    = sslb_pkg::RATE_1200;
                                                hw_next      = '0;
                                                hr_next      = '0;
                                                lw_next      = '0;
                                                lr_next      = '0;
                                            end
                                            default: begin
                                            end
                                        endcase
                                        rep2_next = sslb_pkg::REPLY_ACK;
                                    end
                                    sslb_pkg::CMD_LED: begin
                                        if (led_sel != 2'd3) begin
                                            for (int n = 0; n < NL; n++) begin
                                                led_pat_next[n][led_sel] = pat[n];
                                            end
                                        end
                                        rep2_next = sslb_pkg::REPLY_ACK;
                                    end
                                    sslb_pkg::CMD_FREE: begin
                                        used_t    = (PW+1)'(FIFO_DEPTH) - used_f(hw_reg, hr_reg);
                                        rep2_next = 8'(used_t) | sslb_pkg::FREE_FLAG;
                                    end
                                    default: begin
                                    end
                                endcase
                                fs_next = sslb_pkg::FS_PAD0;
                            end
                            sslb_pkg::FS_PAD0: begin
                                last_next = rep2_eff;
                                fs_next   = sslb_pkg::FS_PAD1;
                            end
                            default: begin
                                last_next = 8'h00;
                                fs_next   = sslb_pkg::FS_SYNC;
                            end
                        endcase
                    end
                end
                sslb_pkg::EV_LINE: begin
                    // receiver
                    if (rx_idx_reg == sslb_pkg::RX_IDLE) begin
                        if (!in_line) begin
                            rx_idx_next = sslb_pkg::RX_START;
                            rx_ph_next  = '0;
                            rx_sh_next  = '0;
                        end
                    end else begin
                        ph_t = {1'b0, rx_ph_reg} + (PHW+1)'(1);
                        if (ph_t >= (PHW+1)'(OVERSAMPLE)) begin
                            idx_t = rx_idx_reg + 4'd1;
                            if (idx_t > sslb_pkg::RX_STOP) begin
                                idx_t = sslb_pkg::RX_IDLE;
                            end
                            ph_t = '0;
                        end
                        rx_idx_next = idx_t;
                        rx_ph_next  = PHW'(ph_t);
                        if (idx_t != sslb_pkg::RX_IDLE
                                && ph_t == (PHW+1)'(OVERSAMPLE / 2 - 1)) begin
                            if (idx_t == sslb_pkg::RX_START) begin
                                if (in_line) begin
                                    rx_idx_next = sslb_pkg::RX_IDLE;
                                    rx_ph_next  = '0;
                                end
                            end else if (idx_t == sslb_pkg::RX_STOP) begin
                                if (in_line && ptr_inc(lw_reg) != lr_reg) begin
                                    l_wr    = 1'b1;
                                    lw_next = ptr_inc(lw_reg);
                                end
                            end else begin
                                rx_sh_next = {in_line, rx_sh_reg[7:1]};
                            end
                        end
                    end
                    // transmitter
                    if (tx_step_reg == sslb_pkg::TX_SILENT) begin
                        line_next = 1'b0;
                    end else if (tx_step_reg == sslb_pkg::TX_TONE_HI) begin
                        line_next    = 1'b1;
                        tx_step_next = sslb_pkg::TX_TONE_LO;
                    end else if (tx_step_reg == sslb_pkg::TX_TONE_LO) begin
                        line_next    = 1'b0;
                        tx_step_next = sslb_pkg::TX_TONE_HI;
                    end else if (tx_step_reg >= sslb_pkg::TX_BIT0
                                 && tx_step_reg <= sslb_pkg::TX_BIT7) begin
                        line_next    = tx_sh_eff[0];
                        tx_sh_next   = {1'b0, tx_sh_eff[7:1]};
                        tx_step_next = tx_step_reg + 4'd1;
                    end else if (tx_step_reg >= sslb_pkg::TX_STOP0
                                 && tx_step_reg <= sslb_pkg::TX_STOP2) begin
                        line_next    = 1'b1;
                        tx_step_next = (tx_step_reg == sslb_pkg::TX_STOP2)
                                       ? sslb_pkg::TX_IDLE : tx_step_reg + 4'd1;
                    end else begin
                        if (hw_reg != hr_reg) begin
                            h_rd         = 1'b1;
                            hr_next      = ptr_inc(hr_reg);
                            pend_tx_next = 1'b1;
                            line_next    = 1'b0;
                            tx_step_next = sslb_pkg::TX_BIT0;
                        end else begin
                            line_next    = 1'b1;
                            tx_step_next = sslb_pkg::TX_IDLE;
                        end
                    end
                end
                sslb_pkg::EV_LED: begin
                    scan_t = {1'b0, scan_reg} + (SW+1)'(1);
                    if (scan_t >= (SW+1)'(NL)) begin
                        scan_t = '0;
                    end
                    scan_next  = SW'(scan_t);
                    drive_next = led_pat_reg[SW'(scan_t)];
                end
                default: begin
                end
            endcase
        end

        m_tvalid_next = in_acc ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = in_acc ? {2'b00, drive_next, rate_next, line_next, last_next}
                               : m_tdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            fs_reg       <= sslb_pkg::FS_SYNC;
            cmd_reg      <= '0;
            rep0_reg     <= '0;
            rep1_reg     <= '0;
            rep2_reg     <= '0;
            last_reg     <= '0;
            hw_reg       <= '0;
            hr_reg       <= '0;
            lw_reg       <= '0;
            lr_reg       <= '0;
            rx_idx_reg   <= sslb_pkg::RX_IDLE;
            rx_ph_reg    <= '0;
            rx_sh_reg    <= '0;
            tx_step_reg  <= sslb_pkg::TX_TONE_HI;
            tx_sh_reg    <= '0;
            rate_reg     <= sslb_pkg::RATE_1760;
            for (int n = 0; n < NL; n++) begin
                led_pat_reg[n] <= '0;
            end
            scan_reg     <= '0;
            line_reg     <= 1'b0;
            drive_reg    <= '0;
            pend_rd_reg  <= 1'b0;
            pend_tx_reg  <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            fs_reg       <= fs_next;
            cmd_reg      <= cmd_next;
            rep0_reg     <= rep0_next;
            rep1_reg     <= rep1_next;
            rep2_reg     <= rep2_next;
            last_reg     <= last_next;
            hw_reg       <= hw_next;
            hr_reg       <= hr_next;
            lw_reg       <= lw_next;
            lr_reg       <= lr_next;
            rx_idx_reg   <= rx_idx_next;
            rx_ph_reg    <= rx_ph_next;
            rx_sh_reg    <= rx_sh_next;
            tx_step_reg  <= tx_step_next;
            tx_sh_reg    <= tx_sh_next;
            rate_reg     <= rate_next;
            for (int n = 0; n < NL; n++) begin
                led_pat_reg[n] <= led_pat_next[n];
            end
            scan_reg     <= scan_next;
            line_reg     <= line_next;
            drive_reg    <= drive_next;
            pend_rd_reg  <= pend_rd_next;
            pend_tx_reg  <= pend_tx_next;
        end
    end

    a_acc_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> m_tvalid_reg)
        else $error("accepted event produced no result");

    a_frame_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fs_reg <= sslb_pkg::FS_SYNC)
        else $error("frame step out of range");

    a_rx_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_idx_reg <= sslb_pkg::RX_STOP || rx_idx_reg == sslb_pkg::RX_IDLE)
        else $error("receiver bit index out of range");

    a_tx_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_step_reg <= sslb_pkg::TX_SILENT)
        else $error("transmitter step out of range");

    a_pend_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_rd_reg |-> !pend_tx_reg)
        else $error("both FIFO pops pending at once");

endmodule
`default_nettype wire

FILE: design/sslb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sslb_ram - FIFO storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sslb_ram #(
    parameter int DEPTH = sslb_pkg::FIFO_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire
